@@ rtl/htd_pkg.sv @@
// htd_pkg: shared types, constants and helpers of the huffman tree decoder
// used by htd_walk and huffman_tree_decoder; depends on nothing

package htd_pkg;

    // tree geometry and field widths
    localparam int LEAF_COUNT  = 256;
    localparam int SYMBOL_BITS = 8;
    localparam int CHILD_W     = 9;
    localparam int SLOT_W      = 8;
    localparam int SYM_W       = 8;
    localparam int COUNT_W     = 8;
    localparam int TOTAL_W     = 32;
    localparam int TABLE_DEPTH = 255;
    localparam int ENTRY_W     = 2 * CHILD_W;

    localparam logic [SYM_W-1:0]   SYM_MASK  = SYM_W'((1 << SYMBOL_BITS) - 1);
    localparam logic [CHILD_W-1:0] LEAF_BASE = CHILD_W'(LEAF_COUNT);

    // command codes of the input word
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_DECODE  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // register indexes, taken from paddr[2]
    localparam logic REG_NODE_COUNT   = 1'b0;
    localparam logic REG_SYMBOL_TOTAL = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [SLOT_W-1:0]  node_slot;
        logic [CHILD_W-1:0] left_child;
        logic [CHILD_W-1:0] right_child;
        logic               code_bit;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             final_symbol;
        logic             bad_child;
    } t_out_word;

    // configuration as seen by the walker
    typedef struct packed {
        logic [COUNT_W-1:0] node_count;
        logic [TOTAL_W-1:0] symbol_total;
        logic               reroot;
        logic [COUNT_W-1:0] reroot_count;
    } t_cfg;

    // node count of zero counts as one
    function automatic logic [CHILD_W-1:0] node_total(input logic [COUNT_W-1:0] cnt);
        logic [CHILD_W-1:0] tot;
        tot = (cnt == '0) ? CHILD_W'(1) : CHILD_W'(cnt);
        return tot;
    endfunction

    // root is the highest loaded internal node
    function automatic logic [CHILD_W-1:0] root_of(input logic [COUNT_W-1:0] cnt);
        logic [CHILD_W-1:0] root;
        root = LEAF_BASE + node_total(cnt) - CHILD_W'(1);
        return root;
    endfunction

endpackage

@@ rtl/htd_ram.sv @@
// htd_ram: generic single-port-write, single-port-read synchronous ram
// read data registered; no dependencies

module htd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 255
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/htd_walk.sv @@
// htd_walk: child table memory and the tree walk (current node, symbol count)
// depends on htd_pkg and htd_ram

module htd_walk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  htd_pkg::t_in_word i_word,
    input  htd_pkg::t_cfg     i_cfg,
    input  logic              i_out_free,
    output logic              o_busy,
    output logic              o_res_valid,
    output htd_pkg::t_out_word o_res_word
);
    import htd_pkg::*;

    logic [CHILD_W-1:0] r_cur;
    logic [CHILD_W-1:0] n_cur;
    logic [TOTAL_W-1:0] r_count;
    logic [TOTAL_W-1:0] n_count;
    logic               r_s1_valid;
    logic               n_s1_valid;
    logic               r_s1_bit;

    logic               load_we;
    logic               dec_re;
    logic [SLOT_W-1:0]  rd_slot;
    logic [ENTRY_W-1:0] rd_entry;
    logic [CHILD_W-1:0] child;
    logic [CHILD_W-1:0] child_off;
    logic [CHILD_W-1:0] root;
    logic [TOTAL_W-1:0] count_inc;
    logic               fire;
    logic               live;
    logic               is_leaf;
    logic               is_node;

    // table write on load (slot 255 has no entry), read on decode
    assign load_we = i_take && (i_word.command == CMD_LOAD)
                     && (i_word.node_slot != SLOT_W'(TABLE_DEPTH));
    assign dec_re  = i_take && (i_word.command == CMD_DECODE);
    // current node is always a loaded internal node, so the offset is the slot
    assign rd_slot = SLOT_W'(r_cur - LEAF_BASE);

    htd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_child_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_word.node_slot),
        .i_wdata ({i_word.right_child, i_word.left_child}),
        .i_re    (dec_re),
        .i_raddr (rd_slot),
        .o_rdata (rd_entry)
    );

    // second half of a decode: pick the child and classify it
    assign fire      = r_s1_valid && i_out_free;
    assign live      = r_count < i_cfg.symbol_total;
    assign child     = r_s1_bit ? rd_entry[ENTRY_W-1:CHILD_W] : rd_entry[CHILD_W-1:0];
    assign child_off = child - LEAF_BASE;
    assign is_leaf   = child < LEAF_BASE;
    assign is_node   = !is_leaf && (child_off < node_total(i_cfg.node_count));
    assign root      = root_of(i_cfg.node_count);
    assign count_inc = r_count + TOTAL_W'(1);

    // walk state update and result
    always_comb begin
        n_cur       = r_cur;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res_word  = '0;
        if (i_cfg.reroot) begin
            n_cur = root_of(i_cfg.reroot_count);
        end else if (i_take && (i_word.command == CMD_RESTART)) begin
            n_cur   = root;
            n_count = '0;
        end else if (fire && live) begin
            if (is_leaf) begin
                n_count                 = count_inc;
                n_cur                   = root;
                o_res_valid             = 1'b1;
                o_res_word.symbol       = SYM_W'(child) & SYM_MASK;
                o_res_word.final_symbol = (count_inc == i_cfg.symbol_total);
            end else if (is_node) begin
                n_cur = child;
            end else begin
                n_cur                = root;
                o_res_valid          = 1'b1;
                o_res_word.bad_child = 1'b1;
            end
        end
    end

    // decode in flight between read and walk update
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (dec_re) begin
            n_s1_valid = 1'b1;
        end else if (fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= root_of(COUNT_W'(1));
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_cur      <= n_cur;
            r_count    <= n_count;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_re) begin
            r_s1_bit <= i_word.code_bit;
        end
    end

    assign o_busy = r_s1_valid;

endmodule

@@ rtl/huffman_tree_decoder.sv @@
// huffman_tree_decoder: top level, config registers, walk and output register
// result: via the child table read register, then the output register
// throughput: loads and restarts one word per cycle while no decode is pending;
//   a decode bit stalls input until its table read has updated the walk node
// reset: walk at node 256, count zero, node count 1, total 0; table not cleared
// depends on htd_pkg, htd_walk, htd_ram

module huffman_tree_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  htd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output htd_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import htd_pkg::*;

    logic [COUNT_W-1:0] r_node_count;
    logic [TOTAL_W-1:0] r_symbol_total;
    logic               cfg_wr;
    t_cfg               cfg;
    logic               take;
    logic               busy;
    logic               out_free;
    logic               res_valid;
    t_out_word          res_word;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_word          r_out_word;

    // register writes
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count   <= COUNT_W'(1);
            r_symbol_total <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NODE_COUNT) begin
                r_node_count <= pwdata[COUNT_W-1:0];
            end else begin
                r_symbol_total <= pwdata[TOTAL_W-1:0];
            end
        end
    end

    // register reads
    always_comb begin
        case (paddr[2])
            REG_NODE_COUNT:   prdata = 32'(r_node_count);
            REG_SYMBOL_TOTAL: prdata = r_symbol_total;
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        cfg.node_count   = r_node_count;
        cfg.symbol_total = r_symbol_total;
        cfg.reroot       = cfg_wr && (paddr[2] == REG_NODE_COUNT);
        cfg.reroot_count = pwdata[COUNT_W-1:0];
    end

    // input handshake
    assign take       = i_in_valid && !o_in_stall;
    assign o_in_stall = busy;

    htd_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_word      (i_in_word),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res_word  (res_word)
    );

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    a_decode_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in_word.command == CMD_DECODE) |=> o_in_stall)
        else $error("decode word not followed by interlock");

    a_result_from_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word without a decode in flight");

    a_bad_child_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.bad_child) |->
            (o_out_word.symbol == '0 && !o_out_word.final_symbol))
        else $error("bad child word carries a symbol");

endmodule
